>>> sv/sequential_list_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sequential list engine
// Shared concurrent assertion forms, clocked on rising edge with an
// active-low reset that disables checking.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication
`define SLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: ante |-> cons");

// Next-cycle implication
`define SLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: ante |=> cons");

`endif

>>> sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Types, codes and defaults shared by the list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

    // Default sizing
    localparam int SLE_DEPTH      = 64;
    localparam int SLE_DATA_WIDTH = 32;

    // Command codes
    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_DELETE     = 3'd5,
        CMD_REPLACE    = 3'd6,
        CMD_DUMP       = 3'd7
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_POS = 2'd3
    } t_status;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_REP,
        OP_ROT
    } t_cell_op;

    // Input item
    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         position;
        logic signed [31:0] value;
        logic signed [31:0] match_value;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [1:0]         status;
        logic [6:0]         count;
        logic signed [31:0] data;
        logic               data_valid;
        logic               last;
    } t_out_item;

endpackage

`default_nettype wire

>>> sv/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// One list slot: holds a word and takes a new one from itself, a neighbor,
// the head slot or the broadcast value, as the broadcast operation says.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_cell
    import sle_pkg::*;
#(
    parameter int DEPTH      = SLE_DEPTH,
    parameter int DATA_WIDTH = SLE_DATA_WIDTH,
    parameter int INDEX      = 0
) (
    input  wire logic                  i_clk,
    input  wire t_cell_op              i_op,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_k,
    input  wire logic [DATA_WIDTH-1:0] i_val,
    input  wire logic [DATA_WIDTH-1:0] i_match,
    input  wire logic [DATA_WIDTH-1:0] i_prev,
    input  wire logic [DATA_WIDTH-1:0] i_next,
    input  wire logic [DATA_WIDTH-1:0] i_head,
    output logic      [DATA_WIDTH-1:0] o_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IW-1:0] CELL_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // next word select
    always_comb begin
        n_data = r_data;
        unique case (i_op)
            OP_HOLD: n_data = r_data;
            OP_INS: begin
                if (i_k == CELL_IDX) n_data = i_val;
                else if (i_k < CELL_IDX) n_data = i_prev;
            end
            OP_DEL: begin
                if (i_k <= CELL_IDX) n_data = i_next;
            end
            OP_REP: begin
                if (r_data == i_match) n_data = i_val;
            end
            OP_ROT: n_data = (i_k == CELL_IDX) ? i_head : i_next;
            default: n_data = r_data;
        endcase
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> sv/sle_out_fifo.sv
// ----------------------------------------------------------------------------
// sle_out_fifo
// Two-entry result queue that decouples the engine from a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_out_fifo
    import sle_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop   = (r_cnt != 2'd0) && !i_stall;
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

endmodule

`default_nettype wire

>>> sv/sequential_list_engine_core.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words held in a row of cells with a count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one command per transfer.
//   Output channel o_out_valid / i_out_stall carries result items.
//   Every command but dump executes in the cycle it is accepted: the whole
//   row of cells shifts or replaces in parallel, and one result enters a
//   two-entry output queue, so such commands run back to back while the queue has room.
//   Dump streams the list out of the head cell while the row rotates by one
//   slot per cycle when the queue has room: no new command is taken
//   meanwhile, and the row ends in its original order. Dump of an empty
//   list gives a single result at once.
//   Results leave through the registered queue; a dump first enters S_DUMP.
//   When the receiver stalls, the queue fills; with two results waiting
//   the block stalls its input and halts any dump in progress.
//   Reset clears the count, the queue and the control state; the word
//   storage is not cleared and is never output beyond the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sequential_list_engine_core
    import sle_pkg::*;
#(
    parameter int DEPTH      = SLE_DEPTH,
    parameter int DATA_WIDTH = SLE_DATA_WIDTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_left;
    logic [CW-1:0] n_left;

    logic                  w_fire;
    logic                  w_fifo_full;
    logic                  w_full;
    logic [CMPW-1:0]       w_pos;
    logic [CMPW-1:0]       w_cnt;
    logic [63:0]           w_val_ext;
    logic [63:0]           w_match_ext;
    logic [63:0]           w_head_ext;
    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] w_match;
    logic [DATA_WIDTH-1:0] w_cell [DEPTH];

    t_cell_op      c_op;
    logic [IW-1:0] c_k;
    logic          res_push;
    t_status       res_status;
    t_out_item     res_item;

    // input handshake
    assign o_in_stall = (r_state != S_IDLE) || w_fifo_full;
    assign w_fire     = i_in_valid && !o_in_stall;

    // operand normalization to the stored width
    assign w_val_ext   = {{32{i_in_item.value[31]}}, i_in_item.value};
    assign w_match_ext = {{32{i_in_item.match_value[31]}}, i_in_item.match_value};
    assign w_val       = w_val_ext[DATA_WIDTH-1:0];
    assign w_match     = w_match_ext[DATA_WIDTH-1:0];
    assign w_head_ext  = 64'(signed'(w_cell[0]));

    assign w_full = (r_count == CW'(DEPTH));
    assign w_pos  = CMPW'(i_in_item.position);
    assign w_cnt  = CMPW'(r_count);

    // command decode and sequencing
    always_comb begin
        c_op       = OP_HOLD;
        c_k        = '0;
        n_count    = r_count;
        n_state    = r_state;
        n_left     = r_left;
        res_push   = 1'b0;
        res_status = ST_OK;
        res_item   = '0;
        res_item.last = 1'b1;

        if (r_state == S_IDLE) begin
            if (w_fire) begin
                res_push = 1'b1;
                unique case (t_cmd'(i_in_item.cmd))
                    CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                        if (w_full) begin
                            res_status = ST_FULL;
                        end else begin
                            c_op    = OP_INS;
                            c_k     = (t_cmd'(i_in_item.cmd) == CMD_PUSH_BACK)
                                      ? IW'(r_count) : '0;
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_POP_BACK, CMD_POP_FRONT: begin
                        if (r_count == '0) begin
                            res_status = ST_EMPTY;
                        end else begin
                            // pop back only drops the count
                            if (t_cmd'(i_in_item.cmd) == CMD_POP_FRONT) c_op = OP_DEL;
                            n_count = r_count - CW'(1);
                        end
                    end
                    CMD_INSERT: begin
                        if (w_full) begin
                            res_status = ST_FULL;
                        end else if (w_pos == '0 || w_pos > w_cnt + CMPW'(1)) begin
                            res_status = ST_BAD_POS;
                        end else begin
                            c_op    = OP_INS;
                            c_k     = IW'(w_pos - CMPW'(1));
                            n_count = r_count + CW'(1);
                        end
                    end
                    CMD_DELETE: begin
                        if (w_pos == '0 || w_pos > w_cnt) begin
                            res_status = ST_BAD_POS;
                        end else begin
                            c_op    = OP_DEL;
                            c_k     = IW'(w_pos - CMPW'(1));
                            n_count = r_count - CW'(1);
                        end
                    end
                    CMD_REPLACE: begin
                        c_op = OP_REP;
                    end
                    CMD_DUMP: begin
                        // empty list answers at once, otherwise stream
                        if (r_count != '0) begin
                            res_push = 1'b0;
                            n_state  = S_DUMP;
                            n_left   = r_count;
                        end
                    end
                    default: res_status = ST_OK;
                endcase
            end
        end else begin
            // dump: read head, rotate row within the count
            if (!w_fifo_full) begin
                c_op     = OP_ROT;
                c_k      = IW'(r_count - CW'(1));
                res_push = 1'b1;
                res_item.data_valid = 1'b1;
                res_item.data       = w_head_ext[31:0];
                res_item.last       = (r_left == CW'(1));
                n_left   = r_left - CW'(1);
                if (r_left == CW'(1)) n_state = S_IDLE;
            end
        end

        res_item.status = res_status;
        res_item.count  = 7'(n_count);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
        end
    end

    // row of cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        sle_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (c_op),
            .i_k     (c_k),
            .i_val   (w_val),
            .i_match (w_match),
            .i_prev  (w_cell[(gi == 0) ? 0 : gi - 1]),
            .i_next  (w_cell[(gi == DEPTH - 1) ? gi : gi + 1]),
            .i_head  (w_cell[0]),
            .o_data  (w_cell[gi])
        );
    end

    // result queue
    sle_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (res_item),
        .o_full  (w_fifo_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

>>> sv/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the list engine result stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequential_list_engine_core_defines.svh"

module sle_checker
    import sle_pkg::*;
#(
    parameter int DEPTH = SLE_DEPTH
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item i_out_item
);

    // a stalled result stays put
    `SLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_item))

    // only dump entries precede the last result, and they report ok
    `SLE_ASSERT_NOW(a_nonlast_is_entry, i_clk, i_rst_n, i_out_valid && !i_out_item.last, i_out_item.data_valid && (i_out_item.status == ST_OK))

    // results without an entry carry zero data and close the command
    `SLE_ASSERT_NOW(a_no_entry_zero, i_clk, i_rst_n, i_out_valid && !i_out_item.data_valid, (i_out_item.data == '0) && i_out_item.last)

    // an error never comes with data
    `SLE_ASSERT_NOW(a_err_no_data, i_clk, i_rst_n, i_out_valid && (i_out_item.status != ST_OK), !i_out_item.data_valid && i_out_item.last)

    // the reported count never exceeds the capacity
    `SLE_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, i_out_valid, (DEPTH > 127) || (int'(i_out_item.count) <= DEPTH))

endmodule

bind sequential_list_engine_core sle_checker #(
    .DEPTH (DEPTH)
) u_sle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_item  (o_out_item)
);

`default_nettype wire
